// ===== design/tcfe_pkg.sv =====
// Package for the tiny fetch/execute core: sizes, opcodes, request codes
// and the structs that link the core to its register file.
// No dependencies.
package tcfe_pkg;

	localparam int WORD_W = 32;
	localparam int PC_W = 8;

	localparam int REG_AW = 5;
	localparam int NUM_REGS = 1 << REG_AW;
	localparam int MEM_AW = 10;
	localparam int MEM_WORDS = 1 << MEM_AW;
	localparam int PROG_AW = 5;
	localparam int PROG_WORDS = 1 << PROG_AW;

	localparam int PC_MAX = (1 << PC_W) - 1;
	localparam logic [PC_W:0] PROG_END = (PC_W + 1)'(PROG_WORDS);
	localparam logic [PC_W-1:0] PC_TERM =
		(PROG_WORDS > PC_MAX) ? PC_W'(PC_MAX) : PC_W'(PROG_WORDS);
	localparam logic [PC_W-1:0] PC_TOP = PC_W'(PC_MAX);
	localparam logic [MEM_AW-1:0] MEM_LAST = MEM_AW'(MEM_WORDS - 1);

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_EXEC = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic [7:0] OP_PRINT = 8'd0;
	localparam logic [7:0] OP_PUT = 8'd1;
	localparam logic [7:0] OP_ADD = 8'd2;
	localparam logic [7:0] OP_STORE = 8'd3;
	localparam logic [7:0] OP_LOAD = 8'd4;
	localparam logic [7:0] OP_MUL = 8'd5;
	localparam logic [7:0] OP_JUMP = 8'd6;
	localparam logic [7:0] OP_BEQ = 8'd7;
	localparam logic [7:0] OP_BNE = 8'd8;
	localparam logic [7:0] OP_TERM = 8'd9;

	typedef struct packed {
		logic en;
		logic [REG_AW-1:0] addr0;
		logic [REG_AW-1:0] addr1;
	} rf_rd_req_t;

	typedef struct packed {
		logic en;
		logic [REG_AW-1:0] addr;
		logic [WORD_W-1:0] data;
	} rf_wr_t;

endpackage

// ===== design/tcfe_regfile.sv =====
// Register file: two registered read ports, one write port, per-entry
// valid bits so unwritten entries read as zero; same-edge writes bypass.
// Depends on tcfe_pkg.
module tcfe_regfile
	import tcfe_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input rf_rd_req_t rd_req,
	input rf_wr_t wr,
	output logic [WORD_W-1:0] rd_data0,
	output logic [WORD_W-1:0] rd_data1
);

	logic [WORD_W-1:0] mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [WORD_W-1:0] rd0_q;
	logic [WORD_W-1:0] rd1_q;
	logic [WORD_W-1:0] wdata_q;
	logic vld0_q;
	logic vld1_q;
	logic hit0_q;
	logic hit1_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			rd0_q <= mem[rd_req.addr0];
			rd1_q <= mem[rd_req.addr1];
			vld0_q <= vld_q[rd_req.addr0];
			vld1_q <= vld_q[rd_req.addr1];
			hit0_q <= wr.en && (wr.addr == rd_req.addr0);
			hit1_q <= wr.en && (wr.addr == rd_req.addr1);
			wdata_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_data0 = hit0_q ? wdata_q : (vld0_q ? rd0_q : '0);
	assign rd_data1 = hit1_q ? wdata_q : (vld1_q ? rd1_q : '0);

endmodule

// ===== design/tiny_cpu_fetch_execute.sv =====
// Top level of the tiny fetch/execute core: program store, data memory,
// three-stage pipeline and output register.
// Depends on tcfe_pkg and tcfe_regfile.
//
// Input channel (in_valid/in_stall) carries one request per beat: write a
// program word, execute one instruction at pc, or restart pc at zero. The
// output channel (out_valid/out_stall) returns exactly one result beat per
// request, in request order.
// A request passes the stage 1 and stage 2 registers into the output
// register before its result beat can leave.
// Stage 1 fetches from the program store, stage 2 reads the register
// file and resolves the next pc, stage 3 holds the result and writes back.
// Throughput: one beat per cycle for program writes and restarts while
// the output does not stall; an in-range execute keeps in_stall high in
// stage 1: the next fetch address waits on its branch compare in stage 2.
// Reset: pc and the register file read as zero at once; the data memory is
// cleared one word a cycle, all MEM_WORDS (1024) words, with in_stall high.
// A stalled output holds its beat; stages 1 and 2 still fill behind it, so
// up to two more requests are taken before in_stall rises.
module tiny_cpu_fetch_execute
	import tcfe_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] req_type,
	input logic [4:0] program_line,
	input logic [31:0] instruction_word,
	output logic out_valid,
	input logic out_stall,
	output logic print_valid,
	output logic [31:0] print_value,
	output logic [7:0] program_counter,
	output logic finished
);

	logic [WORD_W-1:0] prog_mem [PROG_WORDS];
	logic [WORD_W-1:0] dmem [MEM_WORDS];

	logic [PC_W-1:0] pc_q;
	logic clr_q;
	logic [MEM_AW-1:0] clr_cnt_q;

	logic s1_vld_q;
	logic s1_run_q;
	logic [PC_W-1:0] s1_pc_q;
	logic [WORD_W-1:0] prog_rd_q;

	logic s2_vld_q;
	logic s2_run_q;
	logic [PC_W-1:0] s2_pc_q;
	logic [WORD_W-1:0] s2_instr_q;
	logic [REG_AW-1:0] s2_ra0_q;
	logic [REG_AW-1:0] s2_ra1_q;

	logic s3_vld_q;
	logic s3_wen_q;
	logic s3_load_q;
	logic [REG_AW-1:0] s3_waddr_q;
	logic [WORD_W-1:0] s3_res_q;
	logic s3_print_q;
	logic [WORD_W-1:0] s3_pval_q;
	logic [PC_W-1:0] s3_pc_q;
	logic [WORD_W-1:0] dm_rd_q;

	logic acc;
	logic out_beat;
	logic s3_free;
	logic s2_free;
	logic s1_free;
	logic s2_adv;
	logic s1_adv;
	logic [PC_W-1:0] pc_eff;
	logic pc_in_range;

	logic [7:0] s1_op;
	logic [7:0] s2_op;
	logic [7:0] s2_a;
	logic [7:0] s2_b;
	logic [7:0] s2_c;

	rf_rd_req_t rf_rd;
	rf_wr_t rf_wr;
	logic [WORD_W-1:0] rf_rd0;
	logic [WORD_W-1:0] rf_rd1;
	logic [WORD_W-1:0] wb_val;
	logic [WORD_W-1:0] v0;
	logic [WORD_W-1:0] v1;
	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] prod;
	logic [WORD_W-1:0] res;
	logic wen;
	logic taken;
	logic [PC_W-1:0] pc_new;

	logic dm_we;
	logic [MEM_AW-1:0] dm_waddr;
	logic [WORD_W-1:0] dm_wdata;
	logic dm_re;

	// flow control
	assign out_beat = s3_vld_q && !out_stall;
	assign s3_free = !s3_vld_q || !out_stall;
	assign s2_adv = s2_vld_q && s3_free;
	assign s2_free = !s2_vld_q || s3_free;
	assign s1_adv = s1_vld_q && s2_free;
	assign s1_free = !s1_vld_q || s2_free;

	assign in_stall = clr_q || !s1_free || (s1_vld_q && s1_run_q)
		|| (s2_vld_q && s2_run_q && !s3_free);
	assign acc = in_valid && !in_stall;

	assign pc_eff = (s2_adv && s2_run_q) ? pc_new : pc_q;
	assign pc_in_range = {1'b0, pc_eff} < PROG_END;

	// program store
	always_ff @(posedge clk) begin
		if (acc && (req_type == REQ_WRITE)) begin
			prog_mem[program_line[PROG_AW-1:0]] <= instruction_word;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (req_type == REQ_EXEC) && pc_in_range) begin
			prog_rd_q <= prog_mem[pc_eff[PROG_AW-1:0]];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
			s1_vld_q <= 1'b0;
			s2_vld_q <= 1'b0;
			s3_vld_q <= 1'b0;
		end else begin
			if (acc && (req_type == REQ_RESTART)) begin
				pc_q <= '0;
			end else if (s2_adv && s2_run_q) begin
				pc_q <= pc_new;
			end
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == MEM_LAST) begin
					clr_q <= 1'b0;
				end
			end
			if (acc) begin
				s1_vld_q <= 1'b1;
			end else if (s1_adv) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_vld_q <= 1'b1;
			end else if (s2_adv) begin
				s2_vld_q <= 1'b0;
			end
			if (s2_adv) begin
				s3_vld_q <= 1'b1;
			end else if (out_beat) begin
				s3_vld_q <= 1'b0;
			end
		end
	end

	// stage 1: fetch
	always_ff @(posedge clk) begin
		if (acc) begin
			s1_run_q <= (req_type == REQ_EXEC) && pc_in_range;
			s1_pc_q <= (req_type == REQ_RESTART) ? '0 : pc_eff;
		end
	end

	assign s1_op = prog_rd_q[31:24];

	always_comb begin
		rf_rd.en = s1_adv && s1_run_q;
		rf_rd.addr0 = (s1_op == OP_PRINT) ? '0 : prog_rd_q[8+REG_AW-1:8];
		rf_rd.addr1 = ((s1_op == OP_ADD) || (s1_op == OP_MUL))
			? prog_rd_q[REG_AW-1:0] : prog_rd_q[16+REG_AW-1:16];
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			s2_run_q <= s1_run_q;
			s2_pc_q <= s1_pc_q;
			s2_instr_q <= prog_rd_q;
			s2_ra0_q <= rf_rd.addr0;
			s2_ra1_q <= rf_rd.addr1;
		end
	end

	// register file, written as the result beat leaves
	assign wb_val = s3_load_q ? dm_rd_q : s3_res_q;

	always_comb begin
		rf_wr.en = out_beat && s3_wen_q;
		rf_wr.addr = s3_waddr_q;
		rf_wr.data = wb_val;
	end

	tcfe_regfile u_regfile (
		.clk(clk),
		.arst_n(arst_n),
		.rd_req(rf_rd),
		.wr(rf_wr),
		.rd_data0(rf_rd0),
		.rd_data1(rf_rd1)
	);

	// stage 2: execute
	assign s2_op = s2_instr_q[31:24];
	assign s2_a = s2_instr_q[23:16];
	assign s2_b = s2_instr_q[15:8];
	assign s2_c = s2_instr_q[7:0];

	assign v0 = (s3_vld_q && s3_wen_q && (s3_waddr_q == s2_ra0_q)) ? wb_val : rf_rd0;
	assign v1 = (s3_vld_q && s3_wen_q && (s3_waddr_q == s2_ra1_q)) ? wb_val : rf_rd1;
	assign sum = v0 + v1;
	assign prod = v0 * v1;

	always_comb begin
		res = '0;
		wen = 1'b0;
		taken = 1'b0;
		case (s2_op)
			OP_PUT: begin
				res = {16'b0, s2_b, s2_c};
				wen = 1'b1;
			end
			OP_ADD: begin
				res = sum;
				wen = 1'b1;
			end
			OP_LOAD: begin
				wen = 1'b1;
			end
			OP_MUL: begin
				res = prod;
				wen = 1'b1;
			end
			OP_JUMP: begin
				taken = 1'b1;
			end
			OP_BEQ: begin
				taken = (v1 == v0);
			end
			OP_BNE: begin
				taken = (v1 != v0);
			end
			default: begin
				res = '0;
			end
		endcase
		if (s2_op == OP_TERM) begin
			pc_new = PC_TERM;
		end else if (taken) begin
			pc_new = s2_c;
		end else if (s2_pc_q == PC_TOP) begin
			pc_new = s2_pc_q;
		end else begin
			pc_new = s2_pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			s3_wen_q <= s2_run_q && wen;
			s3_load_q <= s2_op == OP_LOAD;
			s3_waddr_q <= s2_a[REG_AW-1:0];
			s3_res_q <= res;
			s3_print_q <= s2_run_q && (s2_op == OP_PRINT);
			s3_pval_q <= (s2_run_q && (s2_op == OP_PRINT)) ? v0 : '0;
			s3_pc_q <= s2_run_q ? pc_new : s2_pc_q;
		end
	end

	// data memory, swept to zero after reset
	assign dm_we = clr_q || (s2_adv && s2_run_q && (s2_op == OP_STORE));
	assign dm_waddr = clr_q ? clr_cnt_q : v0[MEM_AW-1:0];
	assign dm_wdata = clr_q ? '0 : v1;
	assign dm_re = s2_adv && s2_run_q && (s2_op == OP_LOAD);

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dmem[dm_waddr] <= dm_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (dm_re) begin
			dm_rd_q <= dmem[v0[MEM_AW-1:0]];
		end
	end

	// stage 3: result beat
	assign out_valid = s3_vld_q;
	assign print_valid = s3_print_q;
	assign print_value = s3_pval_q;
	assign program_counter = s3_pc_q;
	assign finished = {1'b0, s3_pc_q} >= PROG_END;

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !(in_valid && !in_stall))
		else $error("request taken during memory clear");

	a_fetch_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_q && s1_run_q) |-> in_stall)
		else $error("request taken before pc resolved");

	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!(acc && (req_type == REQ_RESTART)) && !(s2_adv && s2_run_q)) |=> $stable(pc_q))
		else $error("pc changed without restart or execute");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_vld_q && !s3_free) |=> s2_vld_q)
		else $error("stage 2 beat dropped while blocked");

endmodule
